### rtl/core/vebp_pkg.sv
// ----------------------------------------------------------------------------
// vebp_pkg: shared types and constants
// Request/response payloads, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package vebp_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    localparam logic [1:0] KIND_STAGE  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_RETIRE = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  part_index;
        logic [31:0] part_speed_cap;
        logic [31:0] part_accel;
        logic [31:0] seg_length;
        logic [31:0] blend_half_in;
        logic [31:0] interior_speed_cap;
        logic [31:0] interior_accel;
        logic        stop_before;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  seg_position;
        logic [31:0] env_interior;
        logic [31:0] env_entry;
        logic        last;
    } t_rsp;

    // one stored segment
    typedef struct packed {
        logic [31:0] length;
        logic [31:0] half_in;
        logic [31:0] cap;
        logic [31:0] accel;
        logic        stop;
        logic [32:0] part_len;
    } t_seg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_MUL,
        S_APP_WR,
        S_APP_EXIT,
        S_APP_PART,
        S_W_RD,
        S_W_LEN,
        S_MUL,
        S_SUM,
        S_SQRT,
        S_MIN,
        S_P_RD,
        S_P_LEN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load_req;
        logic       stage_wr;
        logic       div_mul;
        logic       seg_wr;
        logic       exit_wr;
        logic       part_wr;
        logic       seg_rd;
        logic       part_rd;
        logic       len_int;
        logic       len_part;
        logic       mul;
        logic       sum;
        logic       min_int;
        logic       min_part;
        logic       same_ok;
        logic       enext_clr;
        logic       enext_upd;
        logic       emit_simple;
        logic       emit_walk;
        logic [1:0] emit_status;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic hin_nz;
        logic same;
    } t_sts;

endpackage

### rtl/core/vebp_sqrt.sv
// ----------------------------------------------------------------------------
// vebp_sqrt: iterative 64-bit integer square root
// Floored root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vebp_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);
    import vebp_pkg::*;

    logic [63:0] r_v, r_r, r_bit;
    logic        r_run, r_done;
    logic [63:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_bit == 64'd1) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_rad;
            r_r   <= 64'd0;
            r_bit <= 64'd1 << 62;
        end else if (r_run) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

### rtl/core/vebp_dp.sv
// ----------------------------------------------------------------------------
// vebp_dp: envelope datapath
// Segment and part memories, part-length divider, envelope step unit, result register.
// ----------------------------------------------------------------------------
module vebp_dp #(
    parameter int QUEUE_DEPTH = 32,
    parameter int SUB_PARTS   = 4,
    parameter int QAW         = 5,
    parameter int PAW         = 7,
    parameter int KW          = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vebp_pkg::t_cmd    i_cmd,
    input  logic [QAW-1:0]    i_seg_addr,
    input  logic [PAW-1:0]    i_part_addr,
    input  logic [KW-1:0]     i_k,
    input  logic [4:0]        i_pos,
    input  vebp_pkg::t_req    i_req,
    output vebp_pkg::t_sts    o_sts,
    output vebp_pkg::t_rsp    o_rsp,
    output logic              o_strobe
);
    import vebp_pkg::*;

    localparam int          PDEPTH = QUEUE_DEPTH * SUB_PARTS;
    // floor(2^36 / SUB_PARTS): reciprocal for the part length
    localparam logic [36:0] RECIP  = 37'((64'd1 << 36) / SUB_PARTS);

    t_seg        seg_mem  [QUEUE_DEPTH];
    logic [31:0] exit_mem [QUEUE_DEPTH];
    logic [31:0] env_mem  [QUEUE_DEPTH];
    logic [63:0] pcap_mem [PDEPTH];
    logic [31:0] penv_mem [PDEPTH];
    logic [63:0] r_staged [SUB_PARTS];

    t_req        r_req;
    logic [69:0] r_prod;
    t_seg        r_seg_rd;
    logic [31:0] r_exit_rd, r_env_rd, r_penv_rd;
    logic [63:0] r_pcap_rd;

    logic [31:0] r_cap, r_a, r_ein;
    logic [32:0] r_len;
    logic [63:0] r_sq, r_p, r_rad;
    logic [31:0] r_e, r_eint, r_enext;
    logic        r_same;
    t_rsp        r_rsp;
    logic        r_strobe;

    logic        sq_done;
    logic [31:0] root, e_new;
    logic [32:0] q0, plen, used, len_int;
    logic [36:0] rem;
    logic [64:0] prod_ap, sum_sp;
    t_seg        seg_wd;

    // part length = floor(2*hin / SUB_PARTS), reciprocal plus one correction
    assign q0   = r_prod[68:36];
    assign rem  = 37'({r_req.blend_half_in, 1'b0}) - 37'(q0) * 37'(SUB_PARTS);
    assign plen = (rem >= 37'(SUB_PARTS)) ? q0 + 33'd1 : q0;

    always_comb begin
        seg_wd.length   = r_req.seg_length;
        seg_wd.half_in  = r_req.blend_half_in;
        seg_wd.cap      = r_req.interior_speed_cap;
        seg_wd.accel    = r_req.interior_accel;
        seg_wd.stop     = r_req.stop_before;
        seg_wd.part_len = plen;
    end

    assign used    = 33'(r_seg_rd.half_in) + 33'(r_exit_rd);
    assign len_int = (33'(r_seg_rd.length) > used) ? 33'(r_seg_rd.length) - used : 33'd0;
    assign prod_ap = 65'(r_a) * 65'(r_len);
    assign sum_sp  = 65'(r_sq) + 65'(r_p);
    assign e_new   = (root < r_cap) ? root : r_cap;

    vebp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sum),
        .i_rad   (sum_sp[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_sp[63:0]),
        .o_done  (sq_done),
        .o_root  (root)
    );

    // request capture and staging slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        for (int j = 0; j < SUB_PARTS; j++) begin
            if (i_cmd.stage_wr && 32'(i_req.part_index) == 32'(j)) begin
                r_staged[j] <= {i_req.part_speed_cap, i_req.part_accel};
            end
        end
        if (i_cmd.div_mul) begin
            r_prod <= 70'({r_req.blend_half_in, 1'b0}) * 70'(RECIP);
        end
    end

    // segment memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_wr) begin
            seg_mem[i_seg_addr] <= seg_wd;
        end
        if (i_cmd.seg_wr) begin
            exit_mem[i_seg_addr] <= 32'd0;
        end else if (i_cmd.exit_wr) begin
            exit_mem[i_seg_addr] <= r_req.blend_half_in;
        end
        if (i_cmd.min_int) begin
            env_mem[i_seg_addr] <= e_new;
        end
        if (i_cmd.seg_rd) begin
            r_seg_rd  <= seg_mem[i_seg_addr];
            r_exit_rd <= exit_mem[i_seg_addr];
            r_env_rd  <= env_mem[i_seg_addr];
        end
    end

    // part memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.part_wr) begin
            pcap_mem[i_part_addr] <= r_staged[i_k];
        end
        if (i_cmd.min_part) begin
            penv_mem[i_part_addr] <= e_new;
        end
        if (i_cmd.part_rd) begin
            r_pcap_rd <= pcap_mem[i_part_addr];
            r_penv_rd <= penv_mem[i_part_addr];
        end
    end

    // envelope step: square and product, saturated sum, root, cap
    always_ff @(posedge i_clk) begin
        if (i_cmd.len_int) begin
            r_cap <= r_seg_rd.cap;
            r_a   <= r_seg_rd.accel;
            r_len <= len_int;
            r_ein <= r_enext;
        end else if (i_cmd.len_part) begin
            r_cap <= r_pcap_rd[63:32];
            r_a   <= r_pcap_rd[31:0];
            r_len <= r_seg_rd.part_len;
            r_ein <= r_e;
        end
        if (i_cmd.mul) begin
            r_sq <= 64'(r_ein) * 64'(r_ein);
            r_p  <= prod_ap[64] ? 64'hFFFF_FFFF_FFFF_FFFF : prod_ap[63:0];
        end
        if (i_cmd.min_int) begin
            r_e    <= e_new;
            r_eint <= e_new;
            r_same <= i_cmd.same_ok && (e_new == r_env_rd);
        end else if (i_cmd.min_part) begin
            r_e    <= e_new;
            r_same <= r_same && (e_new == r_penv_rd);
        end
        if (i_cmd.enext_clr) begin
            r_enext <= 32'd0;
        end else if (i_cmd.enext_upd) begin
            r_enext <= r_seg_rd.stop ? 32'd0 : r_e;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_simple || i_cmd.emit_walk;
        end
        if (i_cmd.emit_simple) begin
            r_rsp.status       <= i_cmd.emit_status;
            r_rsp.seg_position <= 5'd0;
            r_rsp.env_interior <= 32'd0;
            r_rsp.env_entry    <= 32'd0;
            r_rsp.last         <= 1'b1;
        end else if (i_cmd.emit_walk) begin
            r_rsp.status       <= STAT_OK;
            r_rsp.seg_position <= i_pos;
            r_rsp.env_interior <= r_eint;
            r_rsp.env_entry    <= r_e;
            r_rsp.last         <= i_cmd.emit_last;
        end
    end

    assign o_sts.sqrt_done = sq_done;
    assign o_sts.hin_nz    = (r_seg_rd.half_in != 32'd0);
    assign o_sts.same      = r_same;
    assign o_rsp           = r_rsp;
    assign o_strobe        = r_strobe;

endmodule

### rtl/core/vebp_ctrl.sv
// ----------------------------------------------------------------------------
// vebp_ctrl: queue and walk sequencer
// Owns head and count, walks newest to oldest and drives datapath commands.
// ----------------------------------------------------------------------------
module vebp_ctrl #(
    parameter int QUEUE_DEPTH = 32,
    parameter int SUB_PARTS   = 4,
    parameter int QAW         = 5,
    parameter int PAW         = 7,
    parameter int KW          = 2,
    parameter int CW          = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vebp_pkg::t_req    i_req,
    input  vebp_pkg::t_sts    i_sts,
    output logic              o_busy,
    output vebp_pkg::t_cmd    o_cmd,
    output logic [QAW-1:0]    o_seg_addr,
    output logic [PAW-1:0]    o_part_addr,
    output logic [KW-1:0]     o_k,
    output logic [4:0]        o_pos
);
    import vebp_pkg::*;

    t_state              r_state, n_state;
    logic [QAW-1:0]      r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [QAW-1:0]      r_i, n_i;
    logic [KW-1:0]       r_k, n_k;
    logic                r_part, n_part;
    logic [RES_CNT_W-1:0] r_n, n_n;

    logic [QAW-1:0]      tail, prev, cur;
    logic                stop;

    function automatic logic [QAW-1:0] phys(input logic [QAW-1:0] head,
                                            input logic [QAW-1:0] pos);
        logic [QAW:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= (QAW+1)'(QUEUE_DEPTH)) begin
            s = s - (QAW+1)'(QUEUE_DEPTH);
        end
        return s[QAW-1:0];
    endfunction

    assign tail = phys(r_head, r_count[QAW-1:0]);
    assign prev = phys(r_head, r_count[QAW-1:0] - QAW'(1));
    assign cur  = phys(r_head, r_i);
    assign stop = i_sts.same || (r_i == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_part  <= 1'b0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_i     <= n_i;
            r_k     <= n_k;
            r_part  <= n_part;
            r_n     <= n_n;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_i         = r_i;
        n_k         = r_k;
        n_part      = r_part;
        n_n         = r_n;
        o_cmd       = '0;
        o_seg_addr  = cur;
        o_part_addr = PAW'(cur) * PAW'(SUB_PARTS) + PAW'(r_k);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_req = 1'b1;
                    case (i_req.kind)
                        KIND_STAGE: begin
                            o_cmd.stage_wr = 1'b1;
                        end
                        KIND_APPEND: begin
                            if (r_count >= CW'(QUEUE_DEPTH)) begin
                                o_cmd.emit_simple = 1'b1;
                                o_cmd.emit_status = STAT_FULL;
                            end else begin
                                n_state = S_APP_MUL;
                            end
                        end
                        KIND_RETIRE: begin
                            o_cmd.emit_simple = 1'b1;
                            if (r_count == '0) begin
                                o_cmd.emit_status = STAT_EMPTY;
                            end else begin
                                o_cmd.emit_status = STAT_OK;
                                n_head  = phys(r_head, QAW'(1));
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_APP_MUL: begin
                o_cmd.div_mul = 1'b1;
                n_state       = S_APP_WR;
            end
            S_APP_WR: begin
                o_cmd.seg_wr = 1'b1;
                o_seg_addr   = tail;
                n_state      = S_APP_EXIT;
            end
            S_APP_EXIT: begin
                o_cmd.exit_wr = (r_count != '0);
                o_seg_addr    = prev;
                n_k           = '0;
                n_state       = S_APP_PART;
            end
            S_APP_PART: begin
                o_cmd.part_wr = 1'b1;
                o_part_addr   = PAW'(tail) * PAW'(SUB_PARTS) + PAW'(r_k);
                if (r_k == KW'(SUB_PARTS - 1)) begin
                    n_count         = r_count + CW'(1);
                    n_i             = r_count[QAW-1:0];
                    n_n             = '0;
                    o_cmd.enext_clr = 1'b1;
                    n_state         = S_W_RD;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_W_RD: begin
                o_cmd.seg_rd = 1'b1;
                n_state      = S_W_LEN;
            end
            S_W_LEN: begin
                o_cmd.len_int = 1'b1;
                n_part        = 1'b0;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SQRT;
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (!r_part) begin
                    o_cmd.min_int = 1'b1;
                    o_cmd.same_ok = ((CW+1)'(r_i) + (CW+1)'(2)) < (CW+1)'(r_count);
                    if (i_sts.hin_nz) begin
                        n_k     = KW'(SUB_PARTS - 1);
                        n_state = S_P_RD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    o_cmd.min_part = 1'b1;
                    if (r_k == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_k     = r_k - KW'(1);
                        n_state = S_P_RD;
                    end
                end
            end
            S_P_RD: begin
                o_cmd.part_rd = 1'b1;
                n_state       = S_P_LEN;
            end
            S_P_LEN: begin
                o_cmd.len_part = 1'b1;
                n_part         = 1'b1;
                n_state        = S_MUL;
            end
            S_EMIT: begin
                o_cmd.enext_upd = 1'b1;
                if (r_n < RES_CNT_W'(MAX_RESULTS)) begin
                    o_cmd.emit_walk = 1'b1;
                    o_cmd.emit_last = stop || (r_n == RES_CNT_W'(MAX_RESULTS - 1));
                    n_n             = r_n + RES_CNT_W'(1);
                end
                if (stop) begin
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i - QAW'(1);
                    n_state = S_W_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_k    = r_k;
    assign o_pos  = 5'(r_i);

endmodule

### rtl/core/velocity_envelope_backward_pass_top.sv
// ----------------------------------------------------------------------------
// velocity_envelope_backward_pass_top: backward speed envelope over a segment queue
// Retire, full append: result strobe in the cycle after accept; stage never goes busy.
// Append: setup (product, segment write, exit write, one part write per sub-part), then per
// visited segment a read, an envelope step for the interior (plus SUB_PARTS parts when
// blended) and an emit; each envelope step waits on the root unit.
// Reset (synchronous, active low) empties the queue; results cannot be stalled.
// ----------------------------------------------------------------------------
module velocity_envelope_backward_pass_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int SUB_PARTS   = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  vebp_pkg::t_req  i_req,
    output vebp_pkg::t_rsp  o_rsp,
    output logic            o_strobe
);
    import vebp_pkg::*;

    // queue address, part address, part index and count widths
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int PAW = $clog2(QUEUE_DEPTH * SUB_PARTS);
    localparam int KW  = (SUB_PARTS > 1) ? $clog2(SUB_PARTS) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    t_cmd           cmd;
    t_sts           sts;
    logic [QAW-1:0] seg_addr;
    logic [PAW-1:0] part_addr;
    logic [KW-1:0]  k;
    logic [4:0]     pos;

    // Controller: accepts a request when start is high and busy is low,
    // keeps head/count, and steps the walk one segment and part at a time.
    vebp_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SUB_PARTS   (SUB_PARTS),
        .QAW         (QAW),
        .PAW         (PAW),
        .KW          (KW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_sts       (sts),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_seg_addr  (seg_addr),
        .o_part_addr (part_addr),
        .o_k         (k),
        .o_pos       (pos)
    );

    // Datapath: memories, envelope step with shared root unit, result register.
    vebp_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SUB_PARTS   (SUB_PARTS),
        .QAW         (QAW),
        .PAW         (PAW),
        .KW          (KW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_seg_addr  (seg_addr),
        .i_part_addr (part_addr),
        .i_k         (k),
        .i_pos       (pos),
        .i_req       (i_req),
        .o_sts       (sts),
        .o_rsp       (o_rsp),
        .o_strobe    (o_strobe)
    );

endmodule

### tb/velocity_envelope_backward_pass_top_tb.sv
// ----------------------------------------------------------------------------
// velocity_envelope_backward_pass_top_tb: self-checking bench for the envelope pass
// Directed table (typed results for the simple cases), a queue fill up to full,
// then random stage/append/retire/unused-kind traffic with sender gaps. Every result is
// checked field by field against an in-bench predictor of the backward walk.
// ----------------------------------------------------------------------------
module velocity_envelope_backward_pass_top_tb;
    import vebp_pkg::*;

    localparam int DEPTH = 32;
    localparam int PARTS = 4;
    localparam logic [1:0] KIND_UNUSED = 2'd3;   // decoded by nobody, no result
    localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;
    localparam int N_RANDOM = 55;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    t_rsp o_rsp;
    logic o_strobe;
    int   errors = 0;

    velocity_envelope_backward_pass_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_rsp(o_rsp), .o_strobe(o_strobe)
    );

    always #1 i_clk = ~i_clk;

    // ---------------- envelope predictor state ----------------
    bit [31:0] q_len[DEPTH], q_hin[DEPTH], q_hout[DEPTH];
    bit [31:0] q_cap[DEPTH], q_acc[DEPTH], q_env[DEPTH];
    bit        q_stop[DEPTH];
    bit [31:0] p_cap[DEPTH*PARTS], p_acc[DEPTH*PARTS], p_env[DEPTH*PARTS];
    bit [31:0] stg_cap[PARTS], stg_acc[PARTS];
    int        head = 0, count = 0;
    t_rsp      envelope_q[$];   // results still owed by the block

    function automatic bit [63:0] floor_sqrt(bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // min(cap, sqrt(e^2 + a*len)), saturating at 2^64-1
    function automatic bit [31:0] limit_speed(bit [31:0] cap, bit [31:0] a,
                                              bit [63:0] len, bit [31:0] e);
        bit [127:0] prod;
        bit [64:0]  total;
        bit [63:0]  r;
        prod  = 128'(a) * 128'(len);
        total = 65'(64'(e) * 64'(e));
        total = (prod[127:64] != 0) ? {1'b1, 64'd0} : total + 65'(prod[63:0]);
        r = floor_sqrt(total[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total[63:0]);
        return (r < 64'(cap)) ? r[31:0] : cap;
    endfunction

    function automatic void push_simple(logic [1:0] st);
        t_rsp x;
        x = '0;
        x.status = st;
        x.last = 1'b1;
        envelope_q.push_back(x);
    endfunction

    // compute the results one accepted request causes and queue them
    function automatic void predict_envelope(t_req r);
        int s, i, k, pidx, n;
        bit [31:0] enext, e_int, e;
        bit [63:0] used, len, part;
        bit same;
        t_rsp x;
        case (r.kind)
            KIND_STAGE: begin
                stg_cap[r.part_index] = r.part_speed_cap;
                stg_acc[r.part_index] = r.part_accel;
            end
            KIND_RETIRE: begin
                if (count == 0) begin
                    push_simple(STAT_EMPTY);
                end else begin
                    head = (head + 1) % DEPTH;
                    count--;
                    push_simple(STAT_OK);
                end
            end
            KIND_APPEND: begin
                if (count >= DEPTH) begin
                    push_simple(STAT_FULL);
                    return;
                end
                s = (head + count) % DEPTH;
                if (count > 0) q_hout[(head + count - 1) % DEPTH] = r.blend_half_in;
                q_len[s] = r.seg_length;
                q_hin[s] = r.blend_half_in;
                q_cap[s] = r.interior_speed_cap;
                q_acc[s] = r.interior_accel;
                q_stop[s] = r.stop_before;
                q_hout[s] = 0;
                for (k = 0; k < PARTS; k++) begin
                    p_cap[s*PARTS + k] = stg_cap[k];
                    p_acc[s*PARTS + k] = stg_acc[k];
                end
                count++;
                // backward walk, newest first
                enext = 0;
                n = 0;
                i = count;
                while (i > 0) begin
                    i--;
                    s = (head + i) % DEPTH;
                    used = 64'(q_hin[s]) + 64'(q_hout[s]);
                    len = (64'(q_len[s]) > used) ? 64'(q_len[s]) - used : 64'd0;
                    e_int = limit_speed(q_cap[s], q_acc[s], len, enext);
                    same = (i + 2 < count) && (e_int == q_env[s]);
                    q_env[s] = e_int;
                    e = e_int;
                    if (q_hin[s] != 0) begin
                        part = (64'(q_hin[s]) * 2) / PARTS;
                        for (k = PARTS - 1; k >= 0; k--) begin
                            pidx = s*PARTS + k;
                            e = limit_speed(p_cap[pidx], p_acc[pidx], part, e);
                            same = same && (e == p_env[pidx]);
                            p_env[pidx] = e;
                        end
                    end
                    enext = q_stop[s] ? 32'd0 : e;
                    if (n < MAX_RESULTS) begin
                        x.status = STAT_OK;
                        x.seg_position = 5'(i);
                        x.env_interior = e_int;
                        x.env_entry = e;
                        x.last = 1'b0;
                        envelope_q.push_back(x);
                        n++;
                    end
                    if (same) break;
                end
                envelope_q[envelope_q.size()-1].last = 1'b1;
            end
            default: ;   // unused kind: ignored
        endcase
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_strobe) begin
            if (envelope_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_rsp);
                errors++;
            end else begin
                want = envelope_q.pop_front();
                if (o_rsp !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, o_rsp);
                    errors++;
                end
            end
        end
    end

    // ---------------- request driver ----------------
    int idle_pct = 0;

    // present one request and hold it until the block takes it
    task automatic issue(t_req r);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predict_envelope(r);
    endtask

    function automatic t_req mk(logic [1:0] kind, logic [1:0] pi, logic [31:0] pc,
                                logic [31:0] pa, logic [31:0] len, logic [31:0] hin,
                                logic [31:0] cap, logic [31:0] acc, logic stop);
        t_req r;
        r.kind = kind; r.part_index = pi; r.part_speed_cap = pc; r.part_accel = pa;
        r.seg_length = len; r.blend_half_in = hin; r.interior_speed_cap = cap;
        r.interior_accel = acc; r.stop_before = stop;
        return r;
    endfunction

    // mostly modest Q16.16 values, sometimes the extremes
    function automatic logic [31:0] rnd_val();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return ALL1;
            2: return $urandom;
            default: return $urandom_range(32'h0040_0000);
        endcase
    endfunction

    function automatic t_req rnd_append();
        return mk(KIND_APPEND, 2'($urandom), $urandom, $urandom, rnd_val(),
                  ($urandom_range(2) == 0) ? 32'd0 : rnd_val(),
                  ($urandom_range(3) == 0) ? ALL1 : rnd_val(), rnd_val(),
                  ($urandom_range(4) == 0));
    endfunction

    typedef struct {
        t_req r;
        bit   typed;   // first result typed in below
        t_rsp want;
    } t_row;

    t_row plan[$];

    initial begin
        t_req r;
        t_rsp got;
        int   k, sel;

        // directed table; all staging slots are written before any blended append
        plan.push_back('{mk(KIND_RETIRE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{STAT_EMPTY, 5'd0, 32'd0, 32'd0, 1'b1}});
        plan.push_back('{mk(KIND_STAGE, 2'd0, ALL1, ALL1, 0, 0, 0, 0, 0), 0, '0});
        plan.push_back('{mk(KIND_STAGE, 2'd1, 32'd0, 32'd0, ALL1, ALL1, ALL1, ALL1, 1),
                         0, '0});
        plan.push_back('{mk(KIND_STAGE, 2'd2, 32'h0002_0000, 32'h0001_0000, 0, 0, 0, 0, 0),
                         0, '0});
        plan.push_back('{mk(KIND_STAGE, 2'd3, ALL1, 32'h0000_8000, 0, 0, 0, 0, 0), 0, '0});
        plan.push_back('{mk(KIND_UNUSED, 2'd3, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, 1),
                         0, '0});
        // zero length and zero caps: envelope is zero
        plan.push_back('{mk(KIND_APPEND, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{STAT_OK, 5'd0, 32'd0, 32'd0, 1'b1}});
        // no cap, full-scale length and accel: saturated term
        plan.push_back('{mk(KIND_APPEND, 0, 0, 0, ALL1, 0, ALL1, ALL1, 0), 0, '0});
        // entry blend and stop at start
        plan.push_back('{mk(KIND_APPEND, 0, 0, 0, 32'h0010_0000, 32'h0002_0000,
                            32'h0008_0000, 32'h0004_0000, 1), 0, '0});
        // blends longer than the segment: usable length clamps at zero
        plan.push_back('{mk(KIND_APPEND, 0, 0, 0, 32'h0001_0000, ALL1, ALL1,
                            32'h0001_0000, 0), 0, '0});
        plan.push_back('{mk(KIND_APPEND, 0, 0, 0, 32'h0030_0000, 32'h0000_0001,
                            32'h0005_0000, 32'h0010_0000, 0), 0, '0});
        plan.push_back('{mk(KIND_APPEND, 0, 0, 0, 32'h0030_0000, 32'd0,
                            32'h0005_0000, 32'h0010_0000, 0), 0, '0});
        plan.push_back('{mk(KIND_RETIRE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{STAT_OK, 5'd0, 32'd0, 32'd0, 1'b1}});
        plan.push_back('{mk(KIND_STAGE, 2'd2, 32'h0003_0000, ALL1, 0, 0, 0, 0, 0), 0, '0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // typed rows cause exactly one result, the newest one in the queue
        foreach (plan[j]) begin
            issue(plan[j].r);
            if (plan[j].typed) begin
                got = envelope_q[$];
                if (got !== plan[j].want) begin
                    $display("%0t: row %0d predicted %p expected %p", $time, j, got,
                             plan[j].want);
                    errors++;
                end
            end
        end

        // fill the queue: long walks up to the result cap, then a rejected append
        idle_pct = 30;
        while (count < DEPTH) issue(rnd_append());
        issue(rnd_append());
        if (envelope_q[$] !== t_rsp'{STAT_FULL, 5'd0, 32'd0, 32'd0, 1'b1}) begin
            $display("%0t: full append predicted %p", $time, envelope_q[$]);
            errors++;
        end

        // random traffic in idle phases: none, heavy gaps, none, moderate gaps
        for (k = 0; k < N_RANDOM; k++) begin
            case (k * 4 / N_RANDOM)
                0: idle_pct = 0;
                1: idle_pct = 69;
                2: idle_pct = 0;
                default: idle_pct = 30;
            endcase
            sel = $urandom_range(99);
            if (sel < 20)
                r = mk(KIND_STAGE, 2'($urandom), rnd_val(), rnd_val(), $urandom,
                       $urandom, $urandom, $urandom, 1'($urandom));
            else if (sel < 30)
                r = mk(KIND_RETIRE, 2'($urandom), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, 1'($urandom));
            else if (sel < 34)
                r = mk(KIND_UNUSED, 2'($urandom), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, 1'($urandom));
            else
                r = rnd_append();
            issue(r);
        end
        start <= 1'b0;

        while (envelope_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/vebp_pkg.sv
rtl/core/vebp_sqrt.sv
rtl/core/vebp_dp.sv
rtl/core/vebp_ctrl.sv
rtl/core/velocity_envelope_backward_pass_top.sv
tb/velocity_envelope_backward_pass_top_tb.sv
